@@ src/fts_pkg.sv @@
// fragment_time_seek shared types and constants
// used by the interfaces, controller, datapath and top level
package fts_pkg;

  localparam int MaxFragments = 1024;
  localparam int IdxW = $clog2(MaxFragments);
  localparam int CntW = IdxW + 1;
  localparam int TimeW = 48;
  localparam int MsW = 58;
  localparam int QueryW = 32;
  localparam int ScaleW = 32;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW = 1;
  localparam int DivW = 64;

  // x/1000 = ((x >> 3) * RecipM) >> RecipShift for any 64-bit x,
  // RecipM being 2^68/125 rounded up
  localparam int RecipShift = 68;
  localparam logic [63:0] RecipM =
    64'(((128'd1 << RecipShift) + 128'd124) / 128'd125);

  localparam logic [CfgIdxW-1:0] CfgTimescale = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFragCount = 1'b1;
  localparam logic [0:0] ActWrite = 1'b0;
  localparam logic [0:0] ActSeek = 1'b1;

  typedef struct packed {
    logic [0:0] action;
    logic [IdxW-1:0] entry_index;
    logic [TimeW-1:0] entry_time;
    logic [QueryW-1:0] query_ms;
  } in_item_t;

  typedef struct packed {
    logic [0:0] status;
    logic [IdxW-1:0] resume_index;
    logic [MsW-1:0] snapped_ms;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_query;   // latch query, start forward multiply
    logic mul_step;     // one partial product step
    logic div_start;    // start back-conversion divider
    logic search_init;
    logic rd_mid;       // issue table read at mid
    logic eval_mid;     // compare read data, update bounds
    logic rd_nb;        // issue read at neighbor
    logic nb_next;      // 0: prev, 1: next
    logic eval_nb;
    logic set_empty;
  } fts_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic search_done;
  } fts_sts_t;

endpackage

@@ src/fts_stream_if.sv @@
// valid/ready channels carrying one input item or one result item
// depends on fts_pkg for the payload types
interface fts_in_if;
  logic valid;
  logic ready;
  fts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_out_if;
  logic valid;
  logic ready;
  fts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/fts_ram.sv @@
// generic single-port RAM with registered read
// no dependencies
module fts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ src/fts_div.sv @@
// restoring divider, one quotient bit per cycle, 64-bit dividend
// depends on fts_pkg
module fts_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fts_pkg::DivW-1:0]      dividend,
  input  logic [fts_pkg::ScaleW-1:0]    divisor,
  output logic                          done,
  output logic [fts_pkg::DivW-1:0]      quotient
);
  localparam int CW = $clog2(fts_pkg::DivW + 1);

  logic [fts_pkg::DivW-1:0] q_r, q_nxt;
  logic [fts_pkg::ScaleW:0] rem_r, rem_nxt;
  logic [fts_pkg::ScaleW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [fts_pkg::ScaleW+1:0] trial;
  logic [fts_pkg::ScaleW:0] shifted;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[fts_pkg::ScaleW-1:0], q_r[fts_pkg::DivW-1]};
    trial = {1'b0, shifted} - {2'b00, dvs_r};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CW'(fts_pkg::DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below divisor so shifted fits ScaleW+1 bits
      if (!trial[fts_pkg::ScaleW+1]) begin
        rem_nxt = trial[fts_pkg::ScaleW:0];
        q_nxt = {q_r[fts_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[fts_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule

@@ src/fts_datapath.sv @@
// seek datapath: conversions, table, search bounds and neighbor pick
// depends on fts_pkg, fts_ram, fts_div
module fts_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fts_pkg::fts_cmd_t             cmd,
  output fts_pkg::fts_sts_t             sts,
  input  fts_pkg::in_item_t             in_item,
  input  logic                          wr_en,
  input  logic [fts_pkg::ScaleW-1:0]    timescale,
  input  logic [fts_pkg::CntW-1:0]      count,
  output fts_pkg::out_item_t            result
);
  localparam int IW = fts_pkg::IdxW;
  localparam int CW = fts_pkg::CntW;
  localparam int TW = fts_pkg::TimeW;

  // forward conversion: query*timescale, then a reciprocal multiply for /1000,
  // one 32x32 product per step
  logic [fts_pkg::QueryW-1:0] q_r;
  logic [2:0] mph_r, mph_nxt;
  logic mul_done_r, mul_done_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [60:0] y_w;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;
  logic [63:0] seek_time;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic found_r, found_nxt;
  logic [TW-1:0] pick_t_r, pick_t_nxt;
  logic [64:0] pick_gap_r, pick_gap_nxt;
  logic [IW-1:0] addr;
  logic [TW-1:0] rdata;
  logic [63:0] quot;
  logic div_done;
  logic [IW-1:0] nb_idx;
  logic [64:0] gap;
  logic [CW:0] sum;
  logic [CW-1:0] mid_calc;
  logic status_r, status_nxt;
  logic [63:0] back_prod;

  // x/1000 = (x >> 3)/125
  assign y_w = prod_r[63:3];

  always_comb begin
    unique case (mph_r)
      3'd0: begin
        mul_a = q_r;
        mul_b = timescale;
      end
      3'd1: begin
        mul_a = y_w[31:0];
        mul_b = fts_pkg::RecipM[31:0];
      end
      3'd2: begin
        mul_a = y_w[31:0];
        mul_b = fts_pkg::RecipM[63:32];
      end
      3'd3: begin
        mul_a = {3'd0, y_w[60:32]};
        mul_b = fts_pkg::RecipM[31:0];
      end
      3'd4: begin
        mul_a = {3'd0, y_w[60:32]};
        mul_b = fts_pkg::RecipM[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pp = {32'd0, mul_a} * {32'd0, mul_b};
  assign seek_time = 64'(acc_r[127:fts_pkg::RecipShift]);
  assign sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc = sum[CW:1];

  always_comb begin
    if (!cmd.nb_next) begin
      nb_idx = (mid_r != '0) ? IW'(mid_r - 1'b1) : IW'(mid_r);
    end else begin
      nb_idx = ((mid_r + 1'b1) < count) ? IW'(mid_r + 1'b1) : IW'(mid_r);
    end
    if (wr_en) begin
      addr = in_item.entry_index;
    end else if (cmd.rd_nb) begin
      addr = nb_idx;
    end else begin
      addr = IW'(mid_calc);
    end
  end

  fts_ram #(.Width(TW), .Depth(fts_pkg::MaxFragments)) u_ram (
    .clk(clk), .we(wr_en), .addr(addr), .wdata(in_item.entry_time), .rdata(rdata)
  );

  assign gap = ({17'd0, rdata} > {1'b0, seek_time}) ?
               ({17'd0, rdata} - {1'b0, seek_time}) :
               ({1'b0, seek_time} - {17'd0, rdata});
  // time*1000 = time*1024 - time*16 - time*8
  assign back_prod = ({6'd0, pick_t_r, 10'd0}) - ({12'd0, pick_t_r, 4'd0})
                   - ({13'd0, pick_t_r, 3'd0});

  fts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(back_prod),
    .divisor(timescale), .done(div_done), .quotient(quot)
  );

  always_comb begin
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    mph_nxt = mph_r;
    mul_done_nxt = 1'b0;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    mid_nxt = mid_r;
    found_nxt = found_r;
    pick_t_nxt = pick_t_r;
    pick_gap_nxt = pick_gap_r;
    status_nxt = status_r;
    if (cmd.load_query) begin
      acc_nxt = '0;
      mph_nxt = '0;
    end else if (cmd.mul_step) begin
      if (mph_r == 3'd0) begin
        prod_nxt = pp;
      end else if (mph_r == 3'd1) begin
        acc_nxt = acc_r + {64'd0, pp};
      end else if (mph_r == 3'd4) begin
        acc_nxt = acc_r + {pp, 64'd0};
      end else begin
        acc_nxt = acc_r + {32'd0, pp, 32'd0};
      end
      if (mph_r == 3'd4) begin
        mul_done_nxt = 1'b1;
      end else begin
        mph_nxt = mph_r + 3'd1;
      end
    end
    if (cmd.search_init) begin
      lo_nxt = '0;
      hi_nxt = count;
      mid_nxt = '0;
      found_nxt = 1'b0;
      status_nxt = 1'b0;
    end
    if (cmd.rd_mid) begin
      mid_nxt = mid_calc;
    end
    if (cmd.eval_mid) begin
      if ({16'd0, rdata} > seek_time) begin
        hi_nxt = mid_r;
      end else if ({16'd0, rdata} < seek_time) begin
        lo_nxt = mid_r + 1'b1;
      end else begin
        found_nxt = 1'b1;
      end
      pick_t_nxt = rdata;
      pick_gap_nxt = gap;
    end
    if (cmd.eval_nb && (gap < pick_gap_r)) begin
      pick_t_nxt = rdata;
      pick_gap_nxt = gap;
    end
    if (cmd.set_empty) begin
      status_nxt = 1'b1;
      mid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_done_r <= 1'b0;
      mph_r <= '0;
    end else begin
      mul_done_r <= mul_done_nxt;
      mph_r <= mph_nxt;
    end
    q_r <= cmd.load_query ? in_item.query_ms : q_r;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    mid_r <= mid_nxt;
    found_r <= found_nxt;
    pick_t_r <= pick_t_nxt;
    pick_gap_r <= pick_gap_nxt;
    status_r <= status_nxt;
  end

  assign sts.mul_done = mul_done_r;
  assign sts.div_done = div_done;
  assign sts.search_done = found_r || !(lo_r < hi_r);

  always_comb begin
    result.status = status_r;
    result.resume_index = status_r ? '0 : IW'(mid_r);
    if (status_r) begin
      result.snapped_ms = '0;
    end else if (timescale == '0) begin
      result.snapped_ms = '1;
    end else begin
      result.snapped_ms = quot[fts_pkg::MsW-1:0];
    end
  end
endmodule

@@ src/fts_ctrl.sv @@
// seek controller: sequences multiply, search, neighbors, divide and output
// depends on fts_pkg
module fts_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [0:0]                 in_action,
  output logic                       in_ready,
  output logic                       wr_en,
  input  logic [fts_pkg::CntW-1:0]   count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fts_pkg::fts_cmd_t          cmd,
  input  fts_pkg::fts_sts_t          sts
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL   = 8'b00000010,
    S_RMID  = 8'b00000100,
    S_EMID  = 8'b00001000,
    S_EPREV = 8'b00010000,
    S_ENEXT = 8'b00100000,
    S_BACK  = 8'b01000000,
    S_DIVB  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept = in_valid && in_ready;
  assign wr_en = accept && (in_action == fts_pkg::ActWrite);

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action == fts_pkg::ActSeek)) begin
          cmd.search_init = 1'b1;
          if (count == '0) begin
            cmd.set_empty = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (sts.mul_done) begin
          state_nxt = S_RMID;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_RMID: begin
        if (sts.search_done) begin
          // read the previous neighbor of the final midpoint
          cmd.rd_nb = 1'b1;
          state_nxt = S_EPREV;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt = S_EMID;
        end
      end
      S_EMID: begin
        cmd.eval_mid = 1'b1;
        state_nxt = S_RMID;
      end
      S_EPREV: begin
        cmd.eval_nb = 1'b1;
        cmd.rd_nb = 1'b1;
        cmd.nb_next = 1'b1;
        state_nxt = S_ENEXT;
      end
      S_ENEXT: begin
        cmd.eval_nb = 1'b1;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        // pick is final now
        cmd.div_start = 1'b1;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        if (sts.div_done) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

@@ src/fragment_time_seek.sv @@
// Nearest-fragment seek over a 1024-entry table of 48-bit fragment start times.
// A write item (action 0) stores one entry in the cycle it is accepted. A seek item
// goes from acceptance through query conversion (a 32x32 multiply by the timescale,
// then four 32x32 reciprocal-multiply steps for the divide by 1000), binary search
// (up to 11 table probes, each a read then a compare, and a final check), the
// neighbor check and divider start, and a serial divide by the timescale for the
// back conversion, before its result is valid. One item is in flight at a time; the
// input is held off while a result waits to be taken. An empty table sets its result
// valid in the cycle after the seek is accepted.
module fragment_time_seek (
  input  logic                          clk,
  input  logic                          rst_n,
  fts_in_if.sink                        in_ch,
  fts_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [fts_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fts_pkg::CfgDataW-1:0]  cfg_data
);
  logic [fts_pkg::ScaleW-1:0] timescale_r;
  logic [fts_pkg::CntW-1:0] count_r, count_sat;
  fts_pkg::fts_cmd_t cmd;
  fts_pkg::fts_sts_t sts;
  fts_pkg::out_item_t result;
  logic wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timescale_r <= fts_pkg::ScaleW'(1000);
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fts_pkg::CfgTimescale: timescale_r <= cfg_data;
        fts_pkg::CfgFragCount: count_r <= cfg_data[fts_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign count_sat = (count_r > fts_pkg::CntW'(fts_pkg::MaxFragments)) ?
                     fts_pkg::CntW'(fts_pkg::MaxFragments) : count_r;

  fts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_action(in_ch.data.action),
    .in_ready(in_ch.ready), .wr_en(wr_en), .count(count_sat),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  fts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_item(in_ch.data),
    .wr_en(wr_en), .timescale(timescale_r), .count(count_sat), .result(result)
  );

  assign out_ch.data = result;
endmodule
